[rtl/pai_pkg.sv]
// Package for the positional insert/delete list.
// Holds the list depth, field widths, action and status codes and the shared structs.
// No dependencies.
`default_nettype none

package pai_pkg;

  // List geometry and field widths.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;
  localparam int ACT_W  = 2;
  localparam int ST_W   = 2;

  // Action codes carried by an input word.
  localparam logic [ACT_W-1:0] ACT_TRAVERSE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd2;

  // Status codes carried by an output word.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  // One output word, as built by the sequencer.
  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } result_t;

  // Request to load the output register.
  typedef struct packed {
    logic    load;
    result_t res;
  } res_load_t;

  // Element memory access for one cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

[rtl/pai_if.sv]
// Handshake interfaces for the input and output words of the insert/delete list.
// Depends on pai_pkg for the field widths.
`default_nettype none

interface pai_req_if
  import pai_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface pai_rsp_if
  import pai_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] element;
  logic [CNT_W-1:0]         count;
  logic                     last;

  modport source (output valid, output status, output element, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input element, input count, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/pai_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module pai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/pai_ctrl.sv]
// Sequencer of the insert/delete list: checks each action, walks the shared index
// counter over the element memory one move at a time and builds the output words.
// Depends on pai_pkg.
`default_nettype none

module pai_ctrl
  import pai_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [ACT_W-1:0]         action,
  input  wire logic [CNT_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     out_free,
  output res_load_t                     res,
  output ram_req_t                      ram,
  input  wire logic [DATA_W-1:0]        rd_data
);

  typedef enum logic [3:0] {
    IDLE, INS_RD, INS_WR, DEL_RD, DEL_WR, TR_RD, TR_DATA, REPLY
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  logic [ST_W-1:0]   rstat;

  logic [CNT_W-1:0]  idx_up;
  logic [CNT_W-1:0]  idx_dn;
  logic              accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_up   = idx + CNT_W'(1);
  assign idx_dn   = idx - CNT_W'(1);

  // Memory access and output word for the current step.
  always_comb begin
    ram       = '0;
    ram.raddr = idx[ADDR_W-1:0];
    res       = '0;
    unique case (state)
      INS_RD: begin
        if (idx == pos) begin
          ram.we    = 1'b1;
          ram.waddr = pos[ADDR_W-1:0];
          ram.wdata = val;
        end else begin
          ram.raddr = idx_dn[ADDR_W-1:0];
        end
      end
      INS_WR, DEL_WR: begin
        ram.we    = 1'b1;
        ram.waddr = idx[ADDR_W-1:0];
        ram.wdata = rd_data;
      end
      DEL_RD: begin
        ram.raddr = idx_up[ADDR_W-1:0];
      end
      TR_DATA: begin
        res.load        = out_free;
        res.res.status  = ST_OK;
        res.res.element = rd_data;
        res.res.count   = count;
        res.res.last    = (idx_up == count);
      end
      REPLY: begin
        res.load        = out_free;
        res.res.status  = rstat;
        res.res.element = '0;
        res.res.count   = count;
        res.res.last    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State, count and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            pos <= position;
            val <= value;
            unique case (action)
              ACT_TRAVERSE: begin
                if (count == '0) begin
                  rstat <= ST_EMPTY;
                  state <= REPLY;
                end else begin
                  idx   <= '0;
                  state <= TR_RD;
                end
              end
              ACT_INSERT: begin
                if (count == CNT_W'(DEPTH)) begin
                  rstat <= ST_FULL;
                  state <= REPLY;
                end else if (position > count) begin
                  rstat <= ST_BADPOS;
                  state <= REPLY;
                end else begin
                  idx   <= count;
                  state <= INS_RD;
                end
              end
              ACT_DELETE: begin
                if (position >= count) begin
                  rstat <= ST_BADPOS;
                  state <= REPLY;
                end else begin
                  idx   <= position;
                  state <= DEL_RD;
                end
              end
              default: begin
                rstat <= ST_OK;
                state <= REPLY;
              end
            endcase
          end
        end
        // Move elements up from the end until the gap reaches the position.
        INS_RD: begin
          if (idx == pos) begin
            count <= count + CNT_W'(1);
            rstat <= ST_OK;
            state <= REPLY;
          end else begin
            state <= INS_WR;
          end
        end
        INS_WR: begin
          idx   <= idx_dn;
          state <= INS_RD;
        end
        // Move elements down over the deleted one until the end.
        DEL_RD: begin
          if (idx_up == count) begin
            count <= count - CNT_W'(1);
            rstat <= ST_OK;
            state <= REPLY;
          end else begin
            state <= DEL_WR;
          end
        end
        DEL_WR: begin
          idx   <= idx_up;
          state <= DEL_RD;
        end
        // Stream the stored elements in order.
        TR_RD: begin
          state <= TR_DATA;
        end
        TR_DATA: begin
          if (out_free) begin
            idx   <= idx_up;
            state <= (idx_up == count) ? IDLE : TR_RD;
          end
        end
        REPLY: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/positional_array_insert_delete.sv]
// Channel  Dir  Handshake     Word fields
// req      in   valid/ready   action, position, value
// rsp      out  valid/ready   status, element, count, last
//
// Each element move is a read and then a write of the single-read-port element memory.
// The output register frees the sequencer as soon as a word is loaded; a stall on
// rsp holds the sequencer at its next output word. Reset clears the count and the
// handshake state; the element memory needs no clearing.
// Top level of the positional insert/delete list; depends on pai_pkg, pai_if,
// pai_ram and pai_ctrl.
`default_nettype none

module positional_array_insert_delete
  import pai_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  pai_req_if.sink   req,
  pai_rsp_if.source rsp
);

  res_load_t         res;
  ram_req_t          ram;
  logic [DATA_W-1:0] rd_data;
  logic              out_free;
  logic              out_valid;
  result_t           out_word;

  assign out_free = !out_valid || rsp.ready;

  pai_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rd_data)
  );

  pai_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .action   (req.action),
    .position (req.position),
    .value    (req.value),
    .out_free (out_free),
    .res      (res),
    .ram      (ram),
    .rd_data  (rd_data)
  );

  // Output register between the sequencer and the rsp channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res.load) begin
      out_word <= res.res;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_word.status;
  assign rsp.element = out_word.element;
  assign rsp.count   = out_word.count;
  assign rsp.last    = out_word.last;

  // The sequencer only loads a word when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res.load |-> out_free)
    else $error("output word loaded while register held");

  // An accepted word keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("input taken on consecutive cycles");

  // The reported count never exceeds the list depth.
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.count <= CNT_W'(DEPTH)))
    else $error("count beyond depth");

  // An empty traverse reports a zero count and ends the reply.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.count == '0 && rsp.last))
    else $error("empty status with stored elements");

endmodule

`default_nettype wire

[verif/positional_array_insert_delete_test.sv]
// Self-checking testbench for the positional insert/delete list: drives action words,
// predicts every result word in its own list model, and compares them field by field.
// Depends on pai_pkg, the pai_req_if/pai_rsp_if interfaces and the RTL top level.
module positional_array_insert_delete_test;
  import pai_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Code 3 has no action assigned; the block must answer it without change.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst;

  pai_req_if req_ch ();
  pai_rsp_if rsp_ch ();

  positional_array_insert_delete u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Local copy of the list, updated as each input word is accepted.
  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_count;
  result_t                  pending_results[$];

  // Run statistics and fault tracking.
  int fault_count;
  int words_sent;
  int results_seen;
  int full_inserts;
  int bad_positions;
  int empty_traversals;

  // Sender and receiver idling controls.
  bit sender_bursty;
  int burst_left;
  int rx_hold_cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Queue one expected result word, stamped with the current list length.
  task automatic queue_result(input logic [ST_W-1:0] status,
                              input logic signed [DATA_W-1:0] element, input logic last);
    result_t word;
    word.status  = status;
    word.element = element;
    word.count   = CNT_W'(list_count);
    word.last    = last;
    pending_results.push_back(word);
  endtask

  // Apply one accepted input word to the local list and queue what it produces.
  task automatic apply_list_action(input logic [ACT_W-1:0] act,
                                   input logic [CNT_W-1:0] pos,
                                   input logic signed [DATA_W-1:0] val);
    int idx;
    case (act)
      ACT_TRAVERSE: begin
        if (list_count == 0) begin
          empty_traversals++;
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (idx = 0; idx < list_count; idx++)
            queue_result(ST_OK, list_mem[idx], idx == list_count - 1);
        end
      end
      ACT_INSERT: begin
        // The full check takes precedence over the position check.
        if (list_count >= DEPTH) begin
          full_inserts++;
          queue_result(ST_FULL, '0, 1'b1);
        end else if (pos > list_count) begin
          bad_positions++;
          queue_result(ST_BADPOS, '0, 1'b1);
        end else begin
          for (idx = list_count; idx > pos; idx--)
            list_mem[idx] = list_mem[idx-1];
          list_mem[pos] = val;
          list_count++;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (pos >= list_count) begin
          bad_positions++;
          queue_result(ST_BADPOS, '0, 1'b1);
        end else begin
          for (idx = pos; idx + 1 < list_count; idx++)
            list_mem[idx] = list_mem[idx+1];
          list_count--;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      default: queue_result(ST_OK, '0, 1'b1);
    endcase
  endtask

  // Offer one input word, optionally after an idle gap, and wait until it is taken.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
    apply_list_action(act, pos, val);
  endtask

  // Stop offering words until every expected result word has been taken.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  // Pick one random word: mostly legal positions, biased toward growing or shrinking.
  task automatic send_random_word(input bit grow);
    logic [ACT_W-1:0]         act;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       pick;
    pick = $urandom_range(0, 99);
    if (pick < 7) act = ACT_TRAVERSE;
    else if (pick < 10) act = ACT_UNUSED;
    else if ($urandom_range(0, 99) < (grow ? 75 : 25)) act = ACT_INSERT;
    else act = ACT_DELETE;
    if ($urandom_range(0, 9) == 0) pos = CNT_W'($urandom_range(0, 127));
    else if (act == ACT_INSERT) pos = CNT_W'($urandom_range(0, list_count));
    else if (list_count > 0) pos = CNT_W'($urandom_range(0, list_count - 1));
    else pos = '0;
    case ($urandom_range(0, 7))
      0:       val = 32'sh7FFF_FFFF;
      1:       val = 32'sh8000_0000;
      2:       val = -32'sd1;
      default: val = $urandom;
    endcase
    send_word(act, pos, val);
  endtask

  // Every action against an empty list.
  task automatic test_empty_list();
    send_word(ACT_TRAVERSE, 7'd0, 32'sd0);
    send_word(ACT_DELETE, 7'd0, 32'sd0);
    send_word(ACT_DELETE, 7'd127, -32'sd1);
    send_word(ACT_INSERT, 7'd1, 32'sd5);
    send_word(ACT_INSERT, 7'd127, -32'sd1);
    send_word(ACT_UNUSED, 7'd0, 32'sd0);
    wait_drained();
  endtask

  // Inserts and deletes at the front, middle and end, with extreme values and positions.
  task automatic test_insert_delete_edges();
    send_word(ACT_INSERT, 7'd0, 32'sh7FFF_FFFF);
    send_word(ACT_INSERT, 7'd0, 32'sh8000_0000);
    send_word(ACT_INSERT, 7'd2, -32'sd1);
    send_word(ACT_INSERT, 7'd1, 32'sd0);
    send_word(ACT_INSERT, 7'd5, 32'sd9);
    send_word(ACT_INSERT, 7'd64, 32'sd9);
    send_word(ACT_TRAVERSE, 7'd0, 32'sd0);
    send_word(ACT_DELETE, 7'd3, 32'sd0);
    send_word(ACT_DELETE, 7'd0, 32'sd0);
    send_word(ACT_INSERT, 7'd1, 32'sh5555_5555);
    send_word(ACT_DELETE, 7'd1, 32'sd0);
    send_word(ACT_DELETE, 7'd2, 32'sd0);
    send_word(ACT_UNUSED, 7'd127, 32'shAAAA_AAAA);
    send_word(ACT_TRAVERSE, 7'd0, 32'sd0);
    send_word(ACT_DELETE, 7'd0, 32'sd0);
    send_word(ACT_DELETE, 7'd0, 32'sd0);
    send_word(ACT_TRAVERSE, 7'd0, 32'sd0);
    wait_drained();
  endtask

  // Random mix that grows the list toward full, then shrinks it toward empty, and so on.
  task automatic test_random_mix(input int num_words);
    bit grow;
    int n;
    grow = 1'b1;
    for (n = 0; n < num_words; n++) begin
      if (n % 50 == 0) sender_bursty = ($urandom_range(0, 3) != 0);
      if (list_count == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (list_count == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
      send_random_word(grow);
    end
    wait_drained();
  endtask

  // Hold the output off for a long stretch while words keep coming, so the input stalls.
  task automatic test_output_backpressure();
    int n;
    sender_bursty  = 1'b0;
    rx_hold_cycles = 400;
    send_word(ACT_TRAVERSE, 7'd0, 32'sd0);
    for (n = 0; n < 24; n++) send_random_word(list_count < DEPTH / 2);
    send_word(ACT_TRAVERSE, 7'd0, 32'sd0);
    wait_drained();
    sender_bursty = 1'b1;
  endtask

  // Result receiver: a long hold-off when asked, otherwise a changing stall pattern.
  initial begin : rsp_sink
    logic [15:0] stall_mask;
    int          phase_cnt;
    stall_mask    = '1;
    phase_cnt     = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (phase_cnt % 64 == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_mask = '1;
            1:       stall_mask = 16'($urandom) | 16'($urandom);
            2:       stall_mask = 16'($urandom);
            default: stall_mask = ~(16'd1 << $urandom_range(0, 15));
          endcase
        end
        rsp_ch.ready <= stall_mask[phase_cnt % 16];
        phase_cnt++;
      end
    end
  end

  // Compare each accepted result word with the oldest expected one.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_fault($sformatf("unexpected result word: status %0d element %0d count %0d last %0b",
                               rsp_ch.status, rsp_ch.element, rsp_ch.count, rsp_ch.last));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.element !== want.element ||
            rsp_ch.count !== want.count || rsp_ch.last !== want.last) begin
          report_fault($sformatf({"result mismatch: expected status %0d element %0d count %0d ",
                                  "last %0b, got status %0d element %0d count %0d last %0b"},
                                 want.status, want.element, want.count, want.last,
                                 rsp_ch.status, rsp_ch.element, rsp_ch.count, rsp_ch.last));
        end
      end
    end
  end

  // Main sequence: reset, directed tests, random traffic, then the verdict.
  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_TRAVERSE;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    list_count       = 0;
    fault_count      = 0;
    words_sent       = 0;
    results_seen     = 0;
    full_inserts     = 0;
    bad_positions    = 0;
    empty_traversals = 0;
    sender_bursty    = 1'b1;
    burst_left       = 0;
    rx_hold_cycles   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_delete_edges();
    test_random_mix(200);
    test_output_backpressure();
    test_random_mix(160);

    // Allow for a late extra word after the last expected one.
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0)
      report_fault($sformatf("%0d expected result words never arrived", pending_results.size()));

    $display("Run sent %0d input words and checked %0d result words.", words_sent, results_seen);
    $display("Full inserts %0d, bad positions %0d, empty traversals %0d, mismatches %0d.",
             full_inserts, bad_positions, empty_traversals, fault_count);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
